@@ src/rpa_pkg.sv @@
// Shared constants, codes and defaults for the reference-counted page allocator.
package rpa_pkg;

    localparam int ADDR_W     = 56;
    localparam int EXT_W      = ADDR_W + 2;
    localparam int REQ_W      = 3;
    localparam int STATUS_W   = 3;
    localparam int REF_OUT_W  = 16;
    localparam int CFG_IDX_W  = 2;

    localparam int NUM_PAGES_DEF   = 32768;
    localparam int PAGE_SHIFT_DEF  = 12;
    localparam int COUNT_WIDTH_DEF = 16;

    localparam logic [REQ_W-1:0] REQ_INIT   = 3'd0;
    localparam logic [REQ_W-1:0] REQ_ALLOC  = 3'd1;
    localparam logic [REQ_W-1:0] REQ_FREE   = 3'd2;
    localparam logic [REQ_W-1:0] REQ_ADDREF = 3'd3;
    localparam logic [REQ_W-1:0] REQ_GETREF = 3'd4;

    localparam logic [STATUS_W-1:0] STAT_OK      = 3'd0;
    localparam logic [STATUS_W-1:0] STAT_OOM     = 3'd1;
    localparam logic [STATUS_W-1:0] STAT_BADADDR = 3'd2;
    localparam logic [STATUS_W-1:0] STAT_UNDER   = 3'd3;
    localparam logic [STATUS_W-1:0] STAT_OVER    = 3'd4;

    localparam logic [CFG_IDX_W-1:0] REG_REGION_BASE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KERNEL_END  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PHYS_TOP    = 2'd2;

    localparam logic [ADDR_W-1:0] REGION_BASE_RST = 56'd2147483648;
    localparam logic [ADDR_W-1:0] KERNEL_END_RST  = 56'd2147483648;
    localparam logic [ADDR_W-1:0] PHYS_TOP_RST    = 56'd2281701376;

endpackage

@@ src/rpa_ram.sv @@
// Single-port-write, single-port-read synchronous RAM with registered read data.
module rpa_ram #(
    parameter int DEPTH = rpa_pkg::NUM_PAGES_DEF,
    parameter int WIDTH = rpa_pkg::COUNT_WIDTH_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

@@ src/rpa_addr_check.sv @@
// Page address validation and page index computation.
module rpa_addr_check #(
    parameter int NUM_PAGES  = rpa_pkg::NUM_PAGES_DEF,
    parameter int PAGE_SHIFT = rpa_pkg::PAGE_SHIFT_DEF,
    parameter int IDX_W      = $clog2(NUM_PAGES)
) (
    input  logic [rpa_pkg::ADDR_W-1:0] addr,
    input  logic [rpa_pkg::ADDR_W-1:0] region_base,
    input  logic [rpa_pkg::ADDR_W-1:0] kernel_end,
    input  logic [rpa_pkg::ADDR_W-1:0] phys_top,
    output logic                       ok,
    output logic [IDX_W-1:0]           idx
);

    localparam int OFF_W = rpa_pkg::ADDR_W - PAGE_SHIFT;

    logic [rpa_pkg::ADDR_W-1:0] base;
    logic [rpa_pkg::ADDR_W-1:0] diff;
    logic [OFF_W-1:0]           off;

    assign base = {region_base[rpa_pkg::ADDR_W-1:PAGE_SHIFT], {PAGE_SHIFT{1'b0}}};
    assign diff = addr - base;
    assign off  = diff[rpa_pkg::ADDR_W-1:PAGE_SHIFT];
    assign idx  = off[IDX_W-1:0];

    assign ok = (addr[PAGE_SHIFT-1:0] == '0) && (addr >= kernel_end) &&
                (addr < phys_top) && (addr >= base) && (off < OFF_W'(NUM_PAGES));

endmodule

@@ src/refcounted_page_allocator_top.sv @@
// Reference-counted page-frame allocator: control, configuration and result register.
// Flow: an accepted request is checked, its count or free-stack entry is read, and the
// write-back and result register update happen once the result register is free; s_ready
// stays low meanwhile, so a new request is taken only after the last is done.
// Reset: a clearing pass over every count-memory entry zeroes it, with s_ready low.
// After reset the free stack is empty and the registers hold their default values.
module refcounted_page_allocator_top #(
    parameter int NUM_PAGES   = rpa_pkg::NUM_PAGES_DEF,
    parameter int PAGE_SHIFT  = rpa_pkg::PAGE_SHIFT_DEF,
    parameter int COUNT_WIDTH = rpa_pkg::COUNT_WIDTH_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [rpa_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [rpa_pkg::ADDR_W-1:0]    cfg_wdata,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [rpa_pkg::REQ_W-1:0]     s_req_type,
    input  logic [rpa_pkg::ADDR_W-1:0]    s_page_addr,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [rpa_pkg::STATUS_W-1:0]  m_status,
    output logic [rpa_pkg::ADDR_W-1:0]    m_alloc_addr,
    output logic [rpa_pkg::REF_OUT_W-1:0] m_ref_count,
    output logic                          m_page_released
);

    localparam int IDX_W     = $clog2(NUM_PAGES);
    localparam int TOP_W     = IDX_W + 1;
    localparam int EXT_W     = rpa_pkg::EXT_W;
    localparam int AW        = rpa_pkg::ADDR_W;
    localparam int CNT_EXT_W = (COUNT_WIDTH > rpa_pkg::REF_OUT_W) ? COUNT_WIDTH
                                                                   : rpa_pkg::REF_OUT_W;
    localparam logic [EXT_W-1:0]       PAGE_BYTES = EXT_W'(1) << PAGE_SHIFT;
    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX  = '1;
    localparam logic [COUNT_WIDTH-1:0] COUNT_ONE  = COUNT_WIDTH'(1);
    localparam logic [IDX_W-1:0]       LAST_IDX   = IDX_W'(NUM_PAGES - 1);
    localparam logic [TOP_W-1:0]       TOP_FULL   = TOP_W'(NUM_PAGES);

    typedef enum logic [1:0] {
        ST_SWEEP,
        ST_IDLE,
        ST_CHECK,
        ST_EXEC
    } state_t;

    state_t state_reg;

    logic [AW-1:0] region_base_reg;
    logic [AW-1:0] kernel_end_reg;
    logic [AW-1:0] phys_top_reg;

    logic [rpa_pkg::REQ_W-1:0] req_reg;
    logic [AW-1:0]             addr_reg;
    logic                      ok_reg;
    logic [IDX_W-1:0]          idx_reg;
    logic [TOP_W-1:0]          top_reg;
    logic [IDX_W-1:0]          sweep_idx_reg;
    logic                      init_reg;
    logic [EXT_W-1:0]          start_reg;
    logic [EXT_W-1:0]          pg_addr_reg;
    logic [EXT_W-1:0]          pg_end_reg;

    logic                      chk_ok;
    logic [IDX_W-1:0]          chk_idx;
    logic [EXT_W-1:0]          base_ext;
    logic [EXT_W-1:0]          start_sum;
    logic                      out_free;
    logic                      sweep_push;

    logic                      cnt_we;
    logic [IDX_W-1:0]          cnt_waddr;
    logic [COUNT_WIDTH-1:0]    cnt_wdata;
    logic                      cnt_re;
    logic [COUNT_WIDTH-1:0]    cnt_rdata;
    logic                      stk_we;
    logic [IDX_W-1:0]          stk_waddr;
    logic [IDX_W-1:0]          stk_wdata;
    logic                      stk_re;
    logic [IDX_W-1:0]          stk_raddr;
    logic [IDX_W-1:0]          stk_rdata;
    logic [TOP_W-1:0]          top_dec;

    logic [rpa_pkg::STATUS_W-1:0] ex_status;
    logic [AW-1:0]                ex_addr;
    logic [COUNT_WIDTH-1:0]       ex_cnt;
    logic                         ex_rel;
    logic                         ex_cnt_we;
    logic [IDX_W-1:0]             ex_cnt_waddr;
    logic [COUNT_WIDTH-1:0]       ex_cnt_wdata;
    logic                         ex_push;
    logic                         ex_pop;
    logic [EXT_W-1:0]             ex_alloc_sum;
    logic [CNT_EXT_W-1:0]         ex_cnt_ext;

    rpa_addr_check #(
        .NUM_PAGES (NUM_PAGES),
        .PAGE_SHIFT(PAGE_SHIFT),
        .IDX_W     (IDX_W)
    ) u_rpa_addr_check (
        .addr       (addr_reg),
        .region_base(region_base_reg),
        .kernel_end (kernel_end_reg),
        .phys_top   (phys_top_reg),
        .ok         (chk_ok),
        .idx        (chk_idx)
    );

    rpa_ram #(
        .DEPTH(NUM_PAGES),
        .WIDTH(COUNT_WIDTH),
        .AW   (IDX_W)
    ) u_rpa_count_ram (
        .aclk (aclk),
        .we   (cnt_we),
        .waddr(cnt_waddr),
        .wdata(cnt_wdata),
        .re   (cnt_re),
        .raddr(chk_idx),
        .rdata(cnt_rdata)
    );

    rpa_ram #(
        .DEPTH(NUM_PAGES),
        .WIDTH(IDX_W),
        .AW   (IDX_W)
    ) u_rpa_stack_ram (
        .aclk (aclk),
        .we   (stk_we),
        .waddr(stk_waddr),
        .wdata(stk_wdata),
        .re   (stk_re),
        .raddr(stk_raddr),
        .rdata(stk_rdata)
    );

    assign s_ready   = (state_reg == ST_IDLE);
    assign out_free  = !m_valid || m_ready;
    assign base_ext  = {2'b00, region_base_reg[AW-1:PAGE_SHIFT], {PAGE_SHIFT{1'b0}}};
    assign start_sum = {2'b00, kernel_end_reg} + PAGE_BYTES - EXT_W'(1);
    assign top_dec   = top_reg - TOP_W'(1);
    assign stk_raddr = top_dec[IDX_W-1:0];

    assign sweep_push = init_reg && (pg_addr_reg >= start_reg) &&
                        (pg_end_reg <= {2'b00, phys_top_reg});

    assign cnt_re = (state_reg == ST_CHECK) &&
                    ((req_reg == rpa_pkg::REQ_FREE) || (req_reg == rpa_pkg::REQ_ADDREF) ||
                     (req_reg == rpa_pkg::REQ_GETREF));
    assign stk_re = (state_reg == ST_CHECK) && (req_reg == rpa_pkg::REQ_ALLOC);

    assign ex_alloc_sum = base_ext + (EXT_W'(stk_rdata) << PAGE_SHIFT);
    assign ex_cnt_ext   = CNT_EXT_W'(ex_cnt);

    always_comb begin
        ex_status    = rpa_pkg::STAT_OK;
        ex_addr      = '0;
        ex_cnt       = '0;
        ex_rel       = 1'b0;
        ex_cnt_we    = 1'b0;
        ex_cnt_waddr = idx_reg;
        ex_cnt_wdata = '0;
        ex_push      = 1'b0;
        ex_pop       = 1'b0;
        unique case (req_reg)
            rpa_pkg::REQ_ALLOC: begin
                if (top_reg == '0) begin
                    ex_status = rpa_pkg::STAT_OOM;
                end else begin
                    ex_pop       = 1'b1;
                    ex_cnt_we    = 1'b1;
                    ex_cnt_waddr = stk_rdata;
                    ex_cnt_wdata = COUNT_ONE;
                    ex_addr      = ex_alloc_sum[AW-1:0];
                    ex_cnt       = COUNT_ONE;
                end
            end
            rpa_pkg::REQ_FREE: begin
                if (!ok_reg) begin
                    ex_status = rpa_pkg::STAT_BADADDR;
                end else if (cnt_rdata == '0) begin
                    ex_status = rpa_pkg::STAT_UNDER;
                end else begin
                    ex_cnt_we    = 1'b1;
                    ex_cnt_wdata = cnt_rdata - COUNT_ONE;
                    ex_cnt       = cnt_rdata - COUNT_ONE;
                    if (cnt_rdata == COUNT_ONE) begin
                        ex_rel  = 1'b1;
                        ex_push = (top_reg < TOP_FULL);
                    end
                end
            end
            rpa_pkg::REQ_ADDREF: begin
                if (!ok_reg) begin
                    ex_status = rpa_pkg::STAT_BADADDR;
                end else if (cnt_rdata == '0) begin
                    ex_status = rpa_pkg::STAT_UNDER;
                end else if (cnt_rdata == COUNT_MAX) begin
                    ex_status = rpa_pkg::STAT_OVER;
                    ex_cnt    = cnt_rdata;
                end else begin
                    ex_cnt_we    = 1'b1;
                    ex_cnt_wdata = cnt_rdata + COUNT_ONE;
                    ex_cnt       = cnt_rdata + COUNT_ONE;
                end
            end
            rpa_pkg::REQ_GETREF: begin
                if (!ok_reg) begin
                    ex_status = rpa_pkg::STAT_BADADDR;
                end else begin
                    ex_cnt = cnt_rdata;
                end
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        cnt_we    = 1'b0;
        cnt_waddr = ex_cnt_waddr;
        cnt_wdata = ex_cnt_wdata;
        stk_we    = 1'b0;
        stk_waddr = top_reg[IDX_W-1:0];
        stk_wdata = idx_reg;
        unique case (state_reg)
            ST_SWEEP: begin
                cnt_we    = 1'b1;
                cnt_waddr = sweep_idx_reg;
                cnt_wdata = '0;
                stk_we    = sweep_push;
                stk_wdata = sweep_idx_reg;
            end
            ST_EXEC: begin
                cnt_we = ex_cnt_we && out_free;
                stk_we = ex_push && out_free;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_SWEEP;
            region_base_reg <= rpa_pkg::REGION_BASE_RST;
            kernel_end_reg  <= rpa_pkg::KERNEL_END_RST;
            phys_top_reg    <= rpa_pkg::PHYS_TOP_RST;
            top_reg         <= '0;
            sweep_idx_reg   <= '0;
            init_reg        <= 1'b0;
            m_valid         <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    rpa_pkg::REG_REGION_BASE: region_base_reg <= cfg_wdata;
                    rpa_pkg::REG_KERNEL_END:  kernel_end_reg  <= cfg_wdata;
                    rpa_pkg::REG_PHYS_TOP:    phys_top_reg    <= cfg_wdata;
                    default: begin
                    end
                endcase
            end
            if (state_reg == ST_EXEC && out_free) begin
                m_valid <= 1'b1;
            end else if (m_valid && m_ready) begin
                m_valid <= 1'b0;
            end
            unique case (state_reg)
                ST_SWEEP: begin
                    if (sweep_push) begin
                        top_reg <= top_reg + TOP_W'(1);
                    end
                    pg_addr_reg   <= pg_end_reg;
                    pg_end_reg    <= pg_end_reg + PAGE_BYTES;
                    if (sweep_idx_reg == LAST_IDX) begin
                        sweep_idx_reg <= '0;
                        state_reg     <= init_reg ? ST_EXEC : ST_IDLE;
                    end else begin
                        sweep_idx_reg <= sweep_idx_reg + IDX_W'(1);
                    end
                end
                ST_IDLE: begin
                    if (s_valid) begin
                        req_reg   <= s_req_type;
                        addr_reg  <= s_page_addr;
                        state_reg <= ST_CHECK;
                    end
                end
                ST_CHECK: begin
                    ok_reg  <= chk_ok;
                    idx_reg <= chk_idx;
                    if (req_reg == rpa_pkg::REQ_INIT) begin
                        init_reg      <= 1'b1;
                        top_reg       <= '0;
                        sweep_idx_reg <= '0;
                        start_reg     <= {start_sum[EXT_W-1:PAGE_SHIFT], {PAGE_SHIFT{1'b0}}};
                        pg_addr_reg   <= base_ext;
                        pg_end_reg    <= base_ext + PAGE_BYTES;
                        state_reg     <= ST_SWEEP;
                    end else begin
                        state_reg <= ST_EXEC;
                    end
                end
                ST_EXEC: begin
                    if (out_free) begin
                        init_reg        <= 1'b0;
                        m_status        <= ex_status;
                        m_alloc_addr    <= ex_addr;
                        m_ref_count     <= ex_cnt_ext[rpa_pkg::REF_OUT_W-1:0];
                        m_page_released <= ex_rel;
                        if (ex_pop) begin
                            top_reg <= top_dec;
                        end else if (ex_push) begin
                            top_reg <= top_reg + TOP_W'(1);
                        end
                        state_reg <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    a_top_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        top_reg <= TOP_FULL)
        else $error("Free stack depth exceeds the number of pages.");

    a_release_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_page_released) |-> (m_status == rpa_pkg::STAT_OK && m_ref_count == '0))
        else $error("A released page reported a nonzero count or an error.");

    a_alloc_aligned: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_alloc_addr != '0) |-> (m_alloc_addr[PAGE_SHIFT-1:0] == '0))
        else $error("Allocated address is not page aligned.");

    a_write_phase: assert property (@(posedge aclk) disable iff (!aresetn)
        (cnt_we || stk_we) |-> (state_reg == ST_SWEEP || state_reg == ST_EXEC))
        else $error("Memory write outside the sweep or write-back phase.");

    a_result_after_check: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (state_reg == ST_CHECK))
        else $error("Accepted transfer did not enter the check phase.");

endmodule

@@ verif/tb_refcounted_page_allocator_top.sv @@
// Testbench for the page allocator: directed table, then random requests checked by a page model.
module tb_refcounted_page_allocator_top;
    import rpa_pkg::*;

    localparam int          PAGES     = NUM_PAGES_DEF;
    localparam int          PG_SHIFT  = PAGE_SHIFT_DEF;
    localparam logic [63:0] PG_BYTES  = 64'd1 << PG_SHIFT;
    localparam logic [63:0] CNT_MAX   = (64'd1 << COUNT_WIDTH_DEF) - 1;
    localparam longint      RUN_LIMIT = 5_000_000;

    localparam logic [REQ_W-1:0] REQ_UNUSED_LO = 3'd5;
    localparam logic [REQ_W-1:0] REQ_UNUSED_HI = 3'd7;

    localparam logic [ADDR_W-1:0] ALL_ONES = {ADDR_W{1'b1}};
    localparam logic [ADDR_W-1:0] TOP_PG   = 56'h87FF_F000;
    localparam logic [ADDR_W-1:0] NEXT_PG  = 56'h87FF_E000;

    typedef struct packed {
        logic [STATUS_W-1:0]  status;
        logic [ADDR_W-1:0]    alloc_addr;
        logic [REF_OUT_W-1:0] ref_count;
        logic                 released;
    } reply_t;

    typedef struct packed {
        logic [REQ_W-1:0]  req;
        logic [ADDR_W-1:0] addr;
        int unsigned       reps;
        bit                typed;
        reply_t            want;
    } dir_row_t;

    typedef struct packed {
        logic [63:0] base;
        logic [63:0] kend;
        logic [63:0] top;
        bit          write_cfg;
        bit          do_init;
        int          items;
        int          mid_init;
        int          mode;
        bit          squeeze;
    } phase_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [ADDR_W-1:0]     cfg_wdata = '0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    logic [REQ_W-1:0]      s_req_type = '0;
    logic [ADDR_W-1:0]     s_page_addr = '0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    logic [STATUS_W-1:0]   m_status;
    logic [ADDR_W-1:0]     m_alloc_addr;
    logic [REF_OUT_W-1:0]  m_ref_count;
    logic                  m_page_released;

    logic [63:0] reg_base = 64'(REGION_BASE_RST);
    logic [63:0] reg_kend = 64'(KERNEL_END_RST);
    logic [63:0] reg_top  = 64'(PHYS_TOP_RST);
    int unsigned page_refs [PAGES];
    int unsigned free_list [PAGES];
    int unsigned free_depth = 0;

    logic [ADDR_W-1:0] live_pages [$];
    reply_t            awaited_replies [$];

    int     src_idle_pct = 0;
    int     dst_idle_pct = 0;
    bit     hold_req = 1'b0;
    int     hold_left = 0;
    int     mismatches = 0;
    longint cycle_count = 0;

    dir_row_t dir_rows [22] = '{
        '{REQ_GETREF, 56'h8000_0000, 1, 1'b1, '{STAT_OK, 56'h0, 16'd0, 1'b0}},
        '{REQ_ALLOC, 56'h0, 1, 1'b1, '{STAT_OOM, 56'h0, 16'd0, 1'b0}},
        '{REQ_FREE, 56'h8000_0000, 1, 1'b1, '{STAT_UNDER, 56'h0, 16'd0, 1'b0}},
        '{REQ_ADDREF, 56'h8000_0000, 1, 1'b1, '{STAT_UNDER, 56'h0, 16'd0, 1'b0}},
        '{REQ_INIT, ALL_ONES, 1, 1'b1, '{STAT_OK, 56'h0, 16'd0, 1'b0}},
        '{REQ_ALLOC, 56'h0, 1, 1'b1, '{STAT_OK, TOP_PG, 16'd1, 1'b0}},
        '{REQ_ALLOC, ALL_ONES, 1, 1'b0, '0},
        '{REQ_GETREF, TOP_PG, 1, 1'b1, '{STAT_OK, 56'h0, 16'd1, 1'b0}},
        '{REQ_ADDREF, TOP_PG, 3, 1'b0, '0},
        '{REQ_ADDREF, TOP_PG, 1, 1'b0, '0},
        '{REQ_GETREF, TOP_PG, 1, 1'b0, '0},
        '{REQ_FREE, TOP_PG, 1, 1'b0, '0},
        '{REQ_FREE, 56'h87FF_F001, 1, 1'b1, '{STAT_BADADDR, 56'h0, 16'd0, 1'b0}},
        '{REQ_GETREF, 56'h7FFF_F000, 1, 1'b1, '{STAT_BADADDR, 56'h0, 16'd0, 1'b0}},
        '{REQ_GETREF, 56'h8800_0000, 1, 1'b1, '{STAT_BADADDR, 56'h0, 16'd0, 1'b0}},
        '{REQ_ADDREF, 56'hFF_FFFF_FFFF_F000, 1, 1'b1, '{STAT_BADADDR, 56'h0, 16'd0, 1'b0}},
        '{REQ_FREE, 56'h0, 1, 1'b1, '{STAT_BADADDR, 56'h0, 16'd0, 1'b0}},
        '{REQ_UNUSED_LO, ALL_ONES, 1, 1'b1, '{STAT_OK, 56'h0, 16'd0, 1'b0}},
        '{REQ_UNUSED_HI, 56'h0, 1, 1'b1, '{STAT_OK, 56'h0, 16'd0, 1'b0}},
        '{REQ_FREE, NEXT_PG, 1, 1'b1, '{STAT_OK, 56'h0, 16'd0, 1'b1}},
        '{REQ_ALLOC, 56'h0, 1, 1'b1, '{STAT_OK, NEXT_PG, 16'd1, 1'b0}},
        '{REQ_FREE, NEXT_PG, 1, 1'b0, '0}
    };

    phase_t phases [7] = '{
        '{64'h8000_0000, 64'h8000_0000, 64'h8800_0000, 1'b0, 1'b0, 250, -1, 0, 1'b0},
        '{64'h8000_0000, 64'h8006_4005, 64'h8007_8007, 1'b1, 1'b1, 300, 150, 0, 1'b0},
        '{64'hFF_FFFF_FFFF_FFFF, 64'h0, 64'hFF_FFFF_FFFF_FFFF, 1'b1, 1'b1, 100, -1, 1, 1'b0},
        '{64'h0, 64'h0, 64'h1_4000, 1'b1, 1'b1, 250, -1, 1, 1'b0},
        '{64'h10_0000, 64'h10_0000, 64'h11_E000, 1'b1, 1'b0, 150, -1, 2, 1'b0},
        '{64'hFF_FFFF_FFFF_6000, 64'h0, 64'hFF_FFFF_FFFF_FFFF, 1'b1, 1'b1, 200, -1, 2, 1'b0},
        '{64'h12_3456_7FFF, 64'h12_3456_9FFF, 64'hFF_FFFF_FFFF_FFFF, 1'b1, 1'b1, 200, -1, 2,
          1'b1}
    };

    refcounted_page_allocator_top u_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_req_type      (s_req_type),
        .s_page_addr     (s_page_addr),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_status        (m_status),
        .m_alloc_addr    (m_alloc_addr),
        .m_ref_count     (m_ref_count),
        .m_page_released (m_page_released)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    function automatic logic [63:0] frame_base();
        return reg_base & ~(PG_BYTES - 1);
    endfunction

    function automatic void push_free(input int unsigned idx);
        if (free_depth < PAGES) begin
            free_list[free_depth] = idx;
            free_depth++;
        end
    endfunction

    function automatic bit locate_page(input logic [63:0] a, output int unsigned idx);
        logic [63:0] off;
        idx = 0;
        if ((a & (PG_BYTES - 1)) != 0) return 1'b0;
        if (a < reg_kend || a >= reg_top || a < frame_base()) return 1'b0;
        off = (a - frame_base()) >> PG_SHIFT;
        if (off >= PAGES) return 1'b0;
        idx = off[31:0];
        return 1'b1;
    endfunction

    function automatic void rebuild_free_list();
        logic [63:0] start;
        logic [63:0] a;
        start = (reg_kend + PG_BYTES - 1) & ~(PG_BYTES - 1);
        free_depth = 0;
        for (int i = 0; i < PAGES; i++) begin
            page_refs[i] = 0;
            a = frame_base() + (64'(i) << PG_SHIFT);
            if (a >= start && a + PG_BYTES <= reg_top) push_free(i);
        end
    endfunction

    function automatic reply_t compute_page_reply(input logic [REQ_W-1:0] req,
                                                  input logic [ADDR_W-1:0] addr);
        reply_t      r;
        int unsigned idx;
        r = '0;
        case (req)
            REQ_INIT: begin
                rebuild_free_list();
            end
            REQ_ALLOC: begin
                if (free_depth == 0) begin
                    r.status = STAT_OOM;
                end else begin
                    free_depth--;
                    idx = free_list[free_depth] % PAGES;
                    page_refs[idx] = 1;
                    r.alloc_addr = ADDR_W'(frame_base() + (64'(idx) << PG_SHIFT));
                    r.ref_count = REF_OUT_W'(1);
                end
            end
            REQ_FREE: begin
                if (!locate_page(64'(addr), idx)) begin
                    r.status = STAT_BADADDR;
                end else if (page_refs[idx] == 0) begin
                    r.status = STAT_UNDER;
                end else begin
                    page_refs[idx]--;
                    r.ref_count = REF_OUT_W'(page_refs[idx]);
                    if (page_refs[idx] == 0) begin
                        push_free(idx);
                        r.released = 1'b1;
                    end
                end
            end
            REQ_ADDREF: begin
                if (!locate_page(64'(addr), idx)) begin
                    r.status = STAT_BADADDR;
                end else if (page_refs[idx] == 0) begin
                    r.status = STAT_UNDER;
                end else if (page_refs[idx] >= CNT_MAX) begin
                    r.status = STAT_OVER;
                    r.ref_count = REF_OUT_W'(page_refs[idx]);
                end else begin
                    page_refs[idx]++;
                    r.ref_count = REF_OUT_W'(page_refs[idx]);
                end
            end
            REQ_GETREF: begin
                if (!locate_page(64'(addr), idx)) r.status = STAT_BADADDR;
                else r.ref_count = REF_OUT_W'(page_refs[idx]);
            end
            default: begin
            end
        endcase
        return r;
    endfunction

    // Mostly pages that are in use, then pages near the edges of the usable range, then noise.
    function automatic logic [ADDR_W-1:0] pick_page_addr();
        logic [63:0] start;
        logic [63:0] lo;
        logic [63:0] hi;
        logic [63:0] idx;
        int unsigned r;
        r = $urandom_range(99);
        if (r < 60 && live_pages.size() != 0) begin
            return live_pages[$urandom_range(live_pages.size() - 1)];
        end
        start = (reg_kend + PG_BYTES - 1) & ~(PG_BYTES - 1);
        lo = (start > frame_base()) ? (start - frame_base()) >> PG_SHIFT : 64'd0;
        hi = (reg_top > frame_base()) ? (reg_top - frame_base()) >> PG_SHIFT : 64'd0;
        if (lo > PAGES) lo = 64'(PAGES);
        if (hi > PAGES + 2) hi = 64'(PAGES + 2);
        if (lo >= 2) lo = lo - 2;
        hi = hi + 2;
        if (hi < lo) hi = lo;
        case ($urandom_range(3))
            0: idx = lo + $urandom_range(3);
            1: idx = (hi > 3) ? hi - $urandom_range(3) : hi;
            default: idx = $urandom_range(32'(hi), 32'(lo));
        endcase
        if (r < 85) return ADDR_W'(frame_base() + (idx << PG_SHIFT));
        if (r < 93) begin
            return ADDR_W'(frame_base() + (idx << PG_SHIFT) + $urandom_range(32'(PG_BYTES - 1), 1));
        end
        return ADDR_W'({$urandom(), $urandom()});
    endfunction

    function automatic void set_idle(input int mode);
        case (mode)
            0: begin src_idle_pct = 19; dst_idle_pct = 73; end
            1: begin src_idle_pct = 73; dst_idle_pct = 19; end
            default: begin src_idle_pct = 0; dst_idle_pct = 0; end
        endcase
    endfunction

    task automatic issue_request(input logic [REQ_W-1:0] req, input logic [ADDR_W-1:0] addr,
                                 input bit typed, input reply_t typed_reply);
        reply_t r;
        int     hit [$];
        r = compute_page_reply(req, addr);
        if (req == REQ_INIT) begin
            live_pages.delete();
        end else if (req == REQ_ALLOC && r.status == STAT_OK) begin
            live_pages.push_back(r.alloc_addr);
        end else if (req == REQ_FREE && r.released) begin
            hit = live_pages.find_first_index with (item == addr);
            if (hit.size() != 0) live_pages.delete(hit[0]);
        end
        if ($urandom_range(99) < src_idle_pct) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < src_idle_pct);
        end
        s_valid <= 1'b1;
        s_req_type <= req;
        s_page_addr <= addr;
        do @(posedge aclk); while (!s_ready);
        awaited_replies.push_back(typed ? typed_reply : r);
    endtask

    task automatic wait_replies();
        s_valid <= 1'b0;
        while (awaited_replies.size() != 0) @(posedge aclk);
    endtask

    task automatic apply_setting(input logic [63:0] base, input logic [63:0] kend,
                                 input logic [63:0] top);
        cfg_wr_en <= 1'b1;
        cfg_index <= REG_REGION_BASE;
        cfg_wdata <= base[ADDR_W-1:0];
        @(posedge aclk);
        cfg_index <= REG_KERNEL_END;
        cfg_wdata <= kend[ADDR_W-1:0];
        @(posedge aclk);
        cfg_index <= REG_PHYS_TOP;
        cfg_wdata <= top[ADDR_W-1:0];
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        reg_base = base;
        reg_kend = kend;
        reg_top = top;
        live_pages.delete();
    endtask

    task automatic note_mismatch(input string why, input reply_t want, input reply_t got);
        mismatches++;
        if (mismatches <= 10) begin
            $display("%s: want status %0d addr %h count %0d released %0b", why,
                     want.status, want.alloc_addr, want.ref_count, want.released);
            $display("    got status %0d addr %h count %0d released %0b",
                     got.status, got.alloc_addr, got.ref_count, got.released);
        end
    endtask

    always @(posedge aclk) begin
        reply_t got;
        reply_t want;
        if (aresetn && m_valid && m_ready) begin
            got = '{m_status, m_alloc_addr, m_ref_count, m_page_released};
            if (awaited_replies.size() == 0) begin
                note_mismatch("Result transfer with nothing awaited", '0, got);
            end else begin
                want = awaited_replies.pop_front();
                if (got.status !== want.status || got.alloc_addr !== want.alloc_addr ||
                    got.ref_count !== want.ref_count || got.released !== want.released) begin
                    note_mismatch("Result transfer differs", want, got);
                end
            end
        end
        if (hold_req) begin
            hold_req = 1'b0;
            hold_left = 400;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= dst_idle_pct);
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > RUN_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial begin
        dir_row_t          row;
        phase_t            ph;
        logic [REQ_W-1:0]  req;
        int unsigned       r;
        set_idle(0);
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (dir_rows[k]) begin
            row = dir_rows[k];
            for (int n = 0; n < row.reps; n++) issue_request(row.req, row.addr, row.typed, row.want);
        end
        wait_replies();

        foreach (phases[p]) begin
            ph = phases[p];
            if (ph.write_cfg) apply_setting(ph.base, ph.kend, ph.top);
            set_idle(ph.mode);
            if (ph.do_init) issue_request(REQ_INIT, pick_page_addr(), 1'b0, '0);
            if (ph.squeeze) hold_req = 1'b1;
            for (int i = 0; i < ph.items; i++) begin
                r = $urandom_range(99);
                if (i == ph.mid_init) req = REQ_INIT;
                else if (r < 30) req = REQ_ALLOC;
                else if (r < 55) req = REQ_FREE;
                else if (r < 75) req = REQ_ADDREF;
                else if (r < 93) req = REQ_GETREF;
                else req = REQ_W'($urandom_range(REQ_UNUSED_HI, REQ_UNUSED_LO));
                issue_request(req, pick_page_addr(), 1'b0, '0);
            end
            wait_replies();
        end

        repeat (12) @(posedge aclk);
        if (mismatches == 0 && awaited_replies.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
